[rtl/dpe_pkg.sv]
// Shared types for the dipole pair energy unit: item layouts, box settings
// and the record passed from the front section to the back section.
// No dependencies.
`default_nettype none

package dpe_pkg;

    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_pos_z;
        logic signed [15:0] first_moment_x;
        logic signed [15:0] first_moment_y;
        logic signed [15:0] first_moment_z;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_pos_z;
        logic signed [15:0] second_moment_x;
        logic signed [15:0] second_moment_y;
        logic signed [15:0] second_moment_z;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] energy;
        logic               coincident;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [30:0] x;
        logic [30:0] y;
        logic [30:0] z;
    } box_t;

    // numerator magnitude and sign, r.r, final scale exponent, zero-separation flag
    typedef struct packed {
        logic [63:0] nm;
        logic        neg;
        logic [29:0] rsq;
        logic [6:0]  k;
        logic        coin;
    } fb_t;

endpackage

`default_nettype wire

[rtl/dpe_front.sv]
// Front section: separation, minimum-image wrap, normalization and the
// numerator M*R - 3*A*B, twelve stages. Uses dpe_pkg.
`default_nettype none

module dpe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  dpe_pkg::box_t     box,
    input  logic              s_valid,
    output logic              s_ready,
    input  dpe_pkg::in_item_t s_item,
    output logic              fb_valid,
    input  logic              fb_ready,
    output dpe_pkg::fb_t      fb_data
);

    logic        en;
    logic [11:0] v_reg;

    logic [30:0]        box_a [3];
    logic signed [32:0] box_s [3];
    logic signed [31:0] p1_in [3];
    logic signed [31:0] p2_in [3];
    logic signed [15:0] mi_in [3];
    logic signed [15:0] mj_in [3];

    logic signed [15:0] mi_reg [6][3];
    logic signed [15:0] mj_reg [6][3];

    logic signed [32:0] d1_reg [3];
    logic signed [32:0] d2_reg [3];
    logic               wrap2_reg [3];
    logic signed [32:0] d3_reg [3];
    logic [31:0]        mag4_reg [3];
    logic               neg4_reg [3];
    logic [31:0]        mag5_reg [3];
    logic               neg5_reg [3];
    logic signed [5:0]  s5_reg;
    logic signed [14:0] v6_reg [3];
    logic signed [31:0] mm7_reg [3];
    logic signed [30:0] a7_reg [3];
    logic signed [30:0] b7_reg [3];
    logic [27:0]        r7_reg [3];
    logic signed [33:0] m8_reg;
    logic signed [32:0] a8_reg;
    logic signed [32:0] b8_reg;
    logic [63:0]        mr9_reg;
    logic [63:0]        ab9_reg;
    logic [63:0]        mr10_reg;
    logic [63:0]        ab10_reg;
    logic [63:0]        nu11_reg;
    logic [63:0]        nm12_reg;
    logic               neg12_reg;
    logic               coin_reg [4:11];
    logic [6:0]         k_reg [5:11];
    logic [29:0]        r_reg [7:11];

    logic [32:0]        mag1_c [3];
    logic               wrap_c [3];
    logic signed [32:0] d3_c [3];
    logic signed [32:0] abs3_c [3];
    logic [31:0]        or_c;
    logic [4:0]         lead_c;
    logic signed [5:0]  s_c;
    logic [5:0]         negs_c;
    logic [31:0]        sh_c [3];
    logic [13:0]        a_c [3];
    logic signed [14:0] v_c [3];
    logic signed [7:0]  s8_c;
    logic signed [7:0]  ksum_c;
    logic signed [29:0] vv_c [3];
    logic signed [64:0] mr_c;
    logic signed [65:0] ab_c;

    assign box_a[0] = box.x;
    assign box_a[1] = box.y;
    assign box_a[2] = box.z;
    assign p1_in[0] = s_item.first_pos_x;
    assign p1_in[1] = s_item.first_pos_y;
    assign p1_in[2] = s_item.first_pos_z;
    assign p2_in[0] = s_item.second_pos_x;
    assign p2_in[1] = s_item.second_pos_y;
    assign p2_in[2] = s_item.second_pos_z;
    assign mi_in[0] = s_item.first_moment_x;
    assign mi_in[1] = s_item.first_moment_y;
    assign mi_in[2] = s_item.first_moment_z;
    assign mj_in[0] = s_item.second_moment_x;
    assign mj_in[1] = s_item.second_moment_y;
    assign mj_in[2] = s_item.second_moment_z;

    // whole section holds while the last stage cannot hand off
    assign en       = !v_reg[11] || fb_ready;
    assign s_ready  = en;
    assign fb_valid = v_reg[11];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            box_s[i]  = signed'({2'b00, box_a[i]});
            mag1_c[i] = d1_reg[i][32] ? 33'(-d1_reg[i]) : 33'(d1_reg[i]);
            wrap_c[i] = (box_a[i] != '0) && ({mag1_c[i], 1'b0} > {3'b000, box_a[i]});
            if (wrap2_reg[i]) begin
                d3_c[i] = d2_reg[i][32] ? d2_reg[i] + box_s[i] : d2_reg[i] - box_s[i];
            end else begin
                d3_c[i] = d2_reg[i];
            end
            abs3_c[i] = d3_reg[i][32] ? -d3_reg[i] : d3_reg[i];
        end

        // leading one of the largest magnitude
        or_c   = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        lead_c = '0;
        for (int b = 0; b < 32; b++) begin
            if (or_c[b]) begin
                lead_c = 5'(b);
            end
        end
        s_c = signed'({1'b0, lead_c}) - 6'sd13;

        negs_c = 6'(-s5_reg);
        for (int i = 0; i < 3; i++) begin
            if (s5_reg[5]) begin
                sh_c[i] = mag5_reg[i] << negs_c[3:0];
            end else begin
                sh_c[i] = mag5_reg[i] >> s5_reg[4:0];
            end
            a_c[i] = sh_c[i][13:0];
            v_c[i] = neg5_reg[i] ? -signed'({1'b0, a_c[i]}) : signed'({1'b0, a_c[i]});
        end
        s8_c   = 8'(s5_reg);
        ksum_c = 8'sd60 - (s8_c + s8_c + s8_c);

        for (int i = 0; i < 3; i++) begin
            vv_c[i] = v6_reg[i] * v6_reg[i];
        end

        mr_c = m8_reg * signed'({1'b0, r_reg[8 - 1]});
        ab_c = a8_reg * b8_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[10:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mi_reg[0][i] <= mi_in[i];
                mj_reg[0][i] <= mj_in[i];
                for (int st = 1; st < 6; st++) begin
                    mi_reg[st][i] <= mi_reg[st - 1][i];
                    mj_reg[st][i] <= mj_reg[st - 1][i];
                end
                d1_reg[i]    <= 33'(p2_in[i]) - 33'(p1_in[i]);
                d2_reg[i]    <= d1_reg[i];
                wrap2_reg[i] <= wrap_c[i];
                d3_reg[i]    <= d3_c[i];
                mag4_reg[i]  <= abs3_c[i][31:0];
                neg4_reg[i]  <= d3_reg[i][32];
                mag5_reg[i]  <= mag4_reg[i];
                neg5_reg[i]  <= neg4_reg[i];
                v6_reg[i]    <= v_c[i];
                mm7_reg[i]   <= mi_reg[5][i] * mj_reg[5][i];
                a7_reg[i]    <= mi_reg[5][i] * v6_reg[i];
                b7_reg[i]    <= mj_reg[5][i] * v6_reg[i];
                r7_reg[i]    <= vv_c[i][27:0];
            end
            s5_reg <= s_c;

            m8_reg   <= 34'(mm7_reg[0]) + 34'(mm7_reg[1]) + 34'(mm7_reg[2]);
            a8_reg   <= 33'(a7_reg[0]) + 33'(a7_reg[1]) + 33'(a7_reg[2]);
            b8_reg   <= 33'(b7_reg[0]) + 33'(b7_reg[1]) + 33'(b7_reg[2]);
            r_reg[7] <= 30'(r7_reg[0]) + 30'(r7_reg[1]) + 30'(r7_reg[2]);

            mr9_reg   <= mr_c[63:0];
            ab9_reg   <= ab_c[63:0];
            mr10_reg  <= mr9_reg;
            ab10_reg  <= ab9_reg + {ab9_reg[62:0], 1'b0};
            nu11_reg  <= mr10_reg - ab10_reg;
            neg12_reg <= nu11_reg[63];
            nm12_reg  <= nu11_reg[63] ? (~nu11_reg + 64'd1) : nu11_reg;

            coin_reg[4] <= (or_c == '0);
            for (int n = 5; n < 12; n++) begin
                coin_reg[n] <= coin_reg[n - 1];
            end
            k_reg[5] <= ksum_c[6:0];
            for (int n = 6; n < 12; n++) begin
                k_reg[n] <= k_reg[n - 1];
            end
            for (int n = 8; n < 12; n++) begin
                r_reg[n] <= r_reg[n - 1];
            end
        end
    end

    always_comb begin
        fb_data.nm   = nm12_reg;
        fb_data.neg  = neg12_reg;
        fb_data.rsq  = r_reg[11];
        fb_data.k    = k_reg[11];
        fb_data.coin = coin_reg[11];
    end

endmodule

`default_nettype wire

[rtl/dpe_queue.sv]
// Four-entry queue between the front and back sections.
// Uses dpe_pkg.
`default_nettype none

module dpe_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  dpe_pkg::fb_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output dpe_pkg::fb_t pop_data
);

    dpe_pkg::fb_t mem_reg [4];
    logic [1:0]   wr_reg;
    logic [1:0]   rd_reg;
    logic [2:0]   cnt_reg;
    logic         do_push;
    logic         do_pop;

    assign full     = (cnt_reg == 3'd4);
    assign empty    = (cnt_reg == 3'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 2'd1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 3'd1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/dpe_back.sv]
// Back section: pipelined square root, denominator R^2*t, quotient bits one
// per stage, saturation and the output register. Uses dpe_pkg.
`default_nettype none

module dpe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  dpe_pkg::fb_t       q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output dpe_pkg::out_item_t m_item
);

    localparam logic [47:0] ENERGY_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ENERGY_MIN = 48'h8000_0000_0000;

    logic        en;
    logic [83:0] bv_reg;
    logic        m_valid_reg;
    dpe_pkg::out_item_t out_reg;
    dpe_pkg::out_item_t out_next;

    // square root stages
    logic [63:0] sq_rem_reg  [32];
    logic [30:0] sq_res_reg  [32];
    logic [63:0] sq_nm_reg   [32];
    logic        sq_neg_reg  [32];
    logic [6:0]  sq_k_reg    [32];
    logic [29:0] sq_rsq_reg  [32];
    logic        sq_coin_reg [32];
    logic [63:0] sq_test     [1:31];
    logic [63:0] sq_rem_next [1:31];
    logic [30:0] sq_res_next [1:31];

    // denominator stages
    logic [30:0]  m1_t_reg;
    logic [59:0]  m1_r2_reg;
    logic [114:0] m1_xhi_reg;
    logic [47:0]  m1_xlo_reg;
    logic         m1_neg_reg;
    logic         m1_coin_reg;
    logic [60:0]  m2_plo_reg;
    logic [60:0]  m2_phi_reg;
    logic [114:0] m2_xhi_reg;
    logic [47:0]  m2_xlo_reg;
    logic         m2_neg_reg;
    logic         m2_coin_reg;
    logic [90:0]  m3_d_reg;
    logic [114:0] m3_xhi_reg;
    logic [47:0]  m3_xlo_reg;
    logic         m3_neg_reg;
    logic         m3_coin_reg;
    logic [162:0] x_c;

    // quotient stages, entry 0 holds the overflow check
    logic [90:0] dv_p_reg    [49];
    logic [47:0] dv_q_reg    [49];
    logic [90:0] dv_d_reg    [49];
    logic [47:0] dv_xlo_reg  [49];
    logic        dv_neg_reg  [49];
    logic        dv_coin_reg [49];
    logic        dv_sat_reg  [49];
    logic [91:0] dv_pp       [1:48];
    logic        dv_ge       [1:48];
    logic [90:0] dv_p_next   [1:48];
    logic [47:0] dv_q_next   [1:48];

    logic [47:0] q_fin;

    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        for (int i = 1; i < 32; i++) begin
            sq_test[i] = ({33'd0, sq_res_reg[i - 1]} << (32 - i)) + (64'd1 << (62 - 2 * i));
            if (sq_rem_reg[i - 1] >= sq_test[i]) begin
                sq_rem_next[i] = sq_rem_reg[i - 1] - sq_test[i];
                sq_res_next[i] = sq_res_reg[i - 1] | (31'd1 << (31 - i));
            end else begin
                sq_rem_next[i] = sq_rem_reg[i - 1];
                sq_res_next[i] = sq_res_reg[i - 1];
            end
        end

        x_c = {99'd0, sq_nm_reg[31]} << sq_k_reg[31];

        for (int j = 1; j < 49; j++) begin
            dv_pp[j] = {dv_p_reg[j - 1], dv_xlo_reg[j - 1][48 - j]};
            dv_ge[j] = dv_pp[j] >= {1'b0, dv_d_reg[j - 1]};
            if (dv_ge[j]) begin
                dv_p_next[j] = 91'(dv_pp[j] - {1'b0, dv_d_reg[j - 1]});
            end else begin
                dv_p_next[j] = dv_pp[j][90:0];
            end
            dv_q_next[j] = dv_q_reg[j - 1] | ({47'd0, dv_ge[j]} << (48 - j));
        end
    end

    always_comb begin
        q_fin    = dv_q_reg[48];
        out_next = '0;
        if (dv_coin_reg[48]) begin
            out_next.coincident = 1'b1;
        end else if (dv_neg_reg[48]) begin
            if (dv_sat_reg[48] || (q_fin[47] && (q_fin[46:0] != '0))) begin
                out_next.energy    = ENERGY_MIN;
                out_next.saturated = 1'b1;
            end else begin
                out_next.energy = 48'd0 - q_fin;
            end
        end else begin
            if (dv_sat_reg[48] || q_fin[47]) begin
                out_next.energy    = ENERGY_MAX;
                out_next.saturated = 1'b1;
            end else begin
                out_next.energy = q_fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            bv_reg      <= {bv_reg[82:0], !q_empty};
            m_valid_reg <= bv_reg[83];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= {2'b00, q_data.rsq, 32'd0};
            sq_res_reg[0]  <= '0;
            sq_nm_reg[0]   <= q_data.nm;
            sq_neg_reg[0]  <= q_data.neg;
            sq_k_reg[0]    <= q_data.k;
            sq_rsq_reg[0]  <= q_data.rsq;
            sq_coin_reg[0] <= q_data.coin;
            for (int i = 1; i < 32; i++) begin
                sq_rem_reg[i]  <= sq_rem_next[i];
                sq_res_reg[i]  <= sq_res_next[i];
                sq_nm_reg[i]   <= sq_nm_reg[i - 1];
                sq_neg_reg[i]  <= sq_neg_reg[i - 1];
                sq_k_reg[i]    <= sq_k_reg[i - 1];
                sq_rsq_reg[i]  <= sq_rsq_reg[i - 1];
                sq_coin_reg[i] <= sq_coin_reg[i - 1];
            end

            m1_t_reg    <= sq_res_reg[31];
            m1_r2_reg   <= sq_rsq_reg[31] * sq_rsq_reg[31];
            m1_xhi_reg  <= x_c[162:48];
            m1_xlo_reg  <= x_c[47:0];
            m1_neg_reg  <= sq_neg_reg[31];
            m1_coin_reg <= sq_coin_reg[31];

            m2_plo_reg  <= m1_r2_reg[29:0] * m1_t_reg;
            m2_phi_reg  <= m1_r2_reg[59:30] * m1_t_reg;
            m2_xhi_reg  <= m1_xhi_reg;
            m2_xlo_reg  <= m1_xlo_reg;
            m2_neg_reg  <= m1_neg_reg;
            m2_coin_reg <= m1_coin_reg;

            m3_d_reg    <= 91'(m2_plo_reg) + (91'(m2_phi_reg) << 30);
            m3_xhi_reg  <= m2_xhi_reg;
            m3_xlo_reg  <= m2_xlo_reg;
            m3_neg_reg  <= m2_neg_reg;
            m3_coin_reg <= m2_coin_reg;

            // quotient of 2^48 or more means saturation; otherwise the upper
            // part is already below the divisor
            dv_sat_reg[0]  <= m3_xhi_reg >= {24'd0, m3_d_reg};
            dv_p_reg[0]    <= m3_xhi_reg[90:0];
            dv_q_reg[0]    <= '0;
            dv_d_reg[0]    <= m3_d_reg;
            dv_xlo_reg[0]  <= m3_xlo_reg;
            dv_neg_reg[0]  <= m3_neg_reg;
            dv_coin_reg[0] <= m3_coin_reg;
            for (int j = 1; j < 49; j++) begin
                dv_p_reg[j]    <= dv_p_next[j];
                dv_q_reg[j]    <= dv_q_next[j];
                dv_sat_reg[j]  <= dv_sat_reg[j - 1];
                dv_d_reg[j]    <= dv_d_reg[j - 1];
                dv_xlo_reg[j]  <= dv_xlo_reg[j - 1];
                dv_neg_reg[j]  <= dv_neg_reg[j - 1];
                dv_coin_reg[j] <= dv_coin_reg[j - 1];
            end

            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[rtl/dipole_pair_energy_min_image_unit.sv]
// Dipole-dipole pair energy with minimum-image separation, top level.
// Holds the box registers; uses dpe_pkg, dpe_front, dpe_queue, dpe_back.
//
// Usage:
//   Box lengths are written through cfg_wen/cfg_index/cfg_wdata (index 0..2 =
//   x, y, z; other indexes are ignored), by the user only while no item is in
//   flight, unchecked by the block. Zero on an axis turns off wrapping there.
//   An item on s_item is taken when s_valid and s_ready are both high; one
//   result leaves on m_item when m_valid and m_ready are both high.
//   Throughput: one item per cycle, sustained while m_ready is high. Every
//   stage of the square root and of the quotient retires one bit per cycle in
//   its own register stage, so a new item enters each cycle unless stalled.
//   Path: 12 front stages, the first loaded at the accepting edge, one queue
//   slot and 85 back stages including the output register.
//   Stalls: when m_ready is low while a result waits, the back section holds;
//   the four-entry queue absorbs items still leaving the front, and s_ready falls only once the
//   queue is full and the front's last stage is occupied.
//   Reset (aresetn low at a clock edge) empties both sections and the queue
//   and clears all box lengths to zero.
`default_nettype none

module dipole_pair_energy_min_image_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  dpe_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output dpe_pkg::out_item_t m_item
);

    localparam logic [1:0] CFG_BOX_X = 2'd0;
    localparam logic [1:0] CFG_BOX_Y = 2'd1;
    localparam logic [1:0] CFG_BOX_Z = 2'd2;

    dpe_pkg::box_t box_reg;
    dpe_pkg::fb_t  f_data;
    dpe_pkg::fb_t  q_data;
    logic          f_valid;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_BOX_X: begin
                    box_reg.x <= cfg_wdata;
                end
                CFG_BOX_Y: begin
                    box_reg.y <= cfg_wdata;
                end
                CFG_BOX_Z: begin
                    box_reg.z <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    dpe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .box      (box_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .fb_valid (f_valid),
        .fb_ready (!q_full),
        .fb_data  (f_data)
    );

    dpe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_valid),
        .push_data (f_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    dpe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire
